[hdl/pfc_pkg.sv]
// Shared types, format and pair codes, register indexes, status codes and byte counts of the pixel format converter.
package pfc_pkg;

	// Pixel layout codes
	localparam logic [2:0] FMT_BGR  = 3'd0;
	localparam logic [2:0] FMT_BGRA = 3'd1;
	localparam logic [2:0] FMT_ABGR = 3'd2;
	localparam logic [2:0] FMT_RGB  = 3'd3;
	localparam logic [2:0] FMT_RGBA = 3'd4;

	// Source/destination pair codes, source in the upper three bits
	localparam logic [5:0] PAIR_RGB_BGR   = {FMT_RGB,  FMT_BGR};
	localparam logic [5:0] PAIR_BGR_RGB   = {FMT_BGR,  FMT_RGB};
	localparam logic [5:0] PAIR_ABGR_RGBA = {FMT_ABGR, FMT_RGBA};
	localparam logic [5:0] PAIR_RGBA_ABGR = {FMT_RGBA, FMT_ABGR};
	localparam logic [5:0] PAIR_RGBA_BGRA = {FMT_RGBA, FMT_BGRA};
	localparam logic [5:0] PAIR_BGRA_RGBA = {FMT_BGRA, FMT_RGBA};
	localparam logic [5:0] PAIR_BGRA_ABGR = {FMT_BGRA, FMT_ABGR};
	localparam logic [5:0] PAIR_ABGR_BGR  = {FMT_ABGR, FMT_BGR};
	localparam logic [5:0] PAIR_ABGR_RGB  = {FMT_ABGR, FMT_RGB};
	localparam logic [5:0] PAIR_RGBA_RGB  = {FMT_RGBA, FMT_RGB};
	localparam logic [5:0] PAIR_BGRA_BGR  = {FMT_BGRA, FMT_BGR};
	localparam logic [5:0] PAIR_RGBA_BGR  = {FMT_RGBA, FMT_BGR};
	localparam logic [5:0] PAIR_BGRA_RGB  = {FMT_BGRA, FMT_RGB};

	// Configuration register indexes
	localparam logic CFG_IN_FORMAT  = 1'b0;
	localparam logic CFG_OUT_FORMAT = 1'b1;

	// Status codes
	localparam logic ST_OK          = 1'b0;
	localparam logic ST_UNSUPPORTED = 1'b1;

	// Byte counts
	localparam logic [2:0] BYTES_THREE = 3'd3;
	localparam logic [2:0] BYTES_FOUR  = 3'd4;

	// Routing decision for one pixel
	typedef struct packed {
		logic [31:0]     direct;
		logic [2:0][7:0] colour;
		logic [7:0]      alpha;
		logic            flat;
		logic            status;
		logic [2:0]      out_bytes;
	} pfc_route_t;

endpackage

[hdl/pixel_format_converter_unit.sv]
// Top level of the pixel format converter: configuration, pipeline and handshake.
//
// Converts one pixel per beat between the BGR, BGRA, ABGR, RGB and RGBA byte
// orders. in_format and out_format are written through the cfg_we / cfg_index /
// cfg_data port; the user must write them only while the pipeline is empty, as
// the block does not enforce it. Both reset to BGR. Input beat: pixel_in and
// last_pixel, taken when in_valid is high and in_stall is low. Output beat:
// pixel_out, out_bytes, status and last_out, taken when out_valid is high and
// out_stall is low. Throughput is one pixel per cycle while out_stall is low.
// Stage one routes the bytes, stage two holds the colour-times-alpha products
// of the three lanes, stage three holds the divided and packed result.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse and the block keeps taking beats while a result waits. A stall on
// the output backs up through the stages; in_stall rises only once all three
// stages hold a pixel. Nothing is dropped or repeated.
// Reset empties the pipeline and sets both formats to BGR.
module pixel_format_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pixel_in,
	input  logic        last_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_out,
	output logic [2:0]  out_bytes,
	output logic        status,
	output logic        last_out
);
	import pfc_pkg::*;

	logic [2:0]  in_format_q, out_format_q;
	pfc_route_t  route;
	pfc_route_t  route_s1;
	logic        last_s1, valid_s1;
	logic [31:0] direct_s2;
	logic        flat_s2, status_s2, last_s2, valid_s2;
	logic [2:0]  bytes_s2;
	logic [2:0][7:0] flat_val;
	logic [31:0] pixel_s3;
	logic [2:0]  bytes_s3;
	logic        status_s3, last_s3, valid_s3;
	logic        load_s1, load_s2, load_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_format_q  <= FMT_BGR;
			out_format_q <= FMT_BGR;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IN_FORMAT) begin
				in_format_q <= cfg_data;
			end else begin
				out_format_q <= cfg_data;
			end
		end
	end

	// Advance a stage when its successor is free or moving on
	assign load_s3  = !valid_s3 || !out_stall;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage one: route the bytes
	pfc_route u_route (
		.in_format  (in_format_q),
		.out_format (out_format_q),
		.pixel      (pixel_in),
		.route      (route)
	);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			route_s1 <= route;
			last_s1  <= last_pixel;
		end
	end

	// Stage two: multiply each colour by alpha
	for (genvar i = 0; i < 3; i++) begin : g_lane
		pfc_lane u_lane (
			.clk     (clk),
			.load_s2 (load_s2),
			.colour  (route_s1.colour[i]),
			.alpha   (route_s1.alpha),
			.flat    (flat_val[i])
		);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			direct_s2 <= route_s1.direct;
			flat_s2   <= route_s1.flat;
			status_s2 <= route_s1.status;
			bytes_s2  <= route_s1.out_bytes;
			last_s2   <= last_s1;
		end
	end

	// Stage three: divide, pack and hold the result
	always_ff @(posedge clk) begin
		if (load_s3) begin
			pixel_s3  <= flat_s2 ? {8'd0, flat_val} : direct_s2;
			bytes_s3  <= bytes_s2;
			status_s3 <= status_s2;
			last_s3   <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign pixel_out = pixel_s3;
	assign out_bytes = bytes_s3;
	assign status    = status_s3;
	assign last_out  = last_s3;

endmodule

[hdl/pfc_route.sv]
// Format pair decode and byte routing of one source pixel.
module pfc_route (
	input  logic [2:0]          in_format,
	input  logic [2:0]          out_format,
	input  logic [31:0]         pixel,
	output pfc_pkg::pfc_route_t route
);
	import pfc_pkg::*;

	logic [7:0] b0, b1, b2, b3;
	logic [5:0] pair;

	assign b0   = pixel[7:0];
	assign b1   = pixel[15:8];
	assign b2   = pixel[23:16];
	assign b3   = pixel[31:24];
	assign pair = {in_format, out_format};

	// Pick the direct word or the colour lanes and alpha to flatten
	always_comb begin
		route.direct = '0;
		route.colour = '0;
		route.alpha  = '0;
		route.flat   = 1'b0;
		route.status = ST_OK;
		case (pair)
			PAIR_RGB_BGR, PAIR_BGR_RGB: begin
				route.direct = {8'd0, b0, b1, b2};
			end
			PAIR_ABGR_RGBA, PAIR_RGBA_ABGR: begin
				route.direct = {b0, b1, b2, b3};
			end
			PAIR_RGBA_BGRA, PAIR_BGRA_RGBA: begin
				route.direct = {b3, b0, b1, b2};
			end
			PAIR_BGRA_ABGR: begin
				route.direct = {b2, b1, b0, b3};
			end
			PAIR_ABGR_BGR: begin
				route.flat   = 1'b1;
				route.colour = {b3, b2, b1};
				route.alpha  = b0;
			end
			PAIR_ABGR_RGB: begin
				route.flat   = 1'b1;
				route.colour = {b1, b2, b3};
				route.alpha  = b0;
			end
			PAIR_RGBA_RGB, PAIR_BGRA_BGR: begin
				route.flat   = 1'b1;
				route.colour = {b2, b1, b0};
				route.alpha  = b3;
			end
			PAIR_RGBA_BGR, PAIR_BGRA_RGB: begin
				route.flat   = 1'b1;
				route.colour = {b0, b1, b2};
				route.alpha  = b3;
			end
			default: begin
				route.status = ST_UNSUPPORTED;
			end
		endcase

		// Three bytes for the packed colour layouts, four otherwise
		if (out_format == FMT_BGR || out_format == FMT_RGB) begin
			route.out_bytes = BYTES_THREE;
		end else begin
			route.out_bytes = BYTES_FOUR;
		end
	end

endmodule

[hdl/pfc_lane.sv]
// One colour lane of alpha flattening: registered product, then divide by 255.
module pfc_lane (
	input  logic       clk,
	input  logic       load_s2,
	input  logic [7:0] colour,
	input  logic [7:0] alpha,
	output logic [7:0] flat
);
	logic [15:0] product_s2;
	logic [16:0] sum;

	// Hold the product while the stage is stalled
	always_ff @(posedge clk) begin
		if (load_s2) begin
			product_s2 <= colour * alpha;
		end
	end

	// floor(x / 255) for every product x, at most 255 * 255: (x + (x >> 8) + 1) >> 8
	assign sum  = {1'b0, product_s2} + {9'd0, product_s2[15:8]} + 17'd1;
	assign flat = sum[15:8];

endmodule

[hdl/pfc_checker.sv]
// Port-level checks of the pixel format converter and their binding.
module pfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] pixel_out,
	input logic [2:0]  out_bytes,
	input logic        status
);
	import pfc_pkg::*;

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(status))
		else $error("stalled output beat changed");

	// Byte count is three or four
	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_bytes == BYTES_THREE || out_bytes == BYTES_FOUR))
		else $error("bad byte count");

	// Unsupported pairs give a zero pixel
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNSUPPORTED |-> pixel_out == 32'd0)
		else $error("unsupported pair with non-zero pixel");

	// Three-byte results leave the top byte clear
	a_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bytes == BYTES_THREE |-> pixel_out[31:24] == 8'd0)
		else $error("top byte set on a three-byte result");

endmodule

bind pixel_format_converter_unit pfc_checker u_pfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_out (pixel_out),
	.out_bytes (out_bytes),
	.status    (status)
);
